// ===== hdl/qdsa_pkg.sv =====
// ----------------------------------------------------------------------------
// qdsa_pkg
// Shared widths, codes and controller/datapath types of the quadrature
// decoder with speed and angle readout.
// ----------------------------------------------------------------------------
package qdsa_pkg;

	// glitch filter counter width and its saturation value
	localparam int FILTER_BITS = 10;
	localparam int CNT_MAX     = (1 << FILTER_BITS) - 1;

	// field and register widths
	localparam int KIND_W     = 2;
	localparam int TIME_W     = 32;
	localparam int COUNT_W    = 32;
	localparam int ANGLE_W    = 16;
	localparam int PPR_W      = 16;
	localparam int GLITCH_W   = 10;
	localparam int CPR_W      = PPR_W + 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// 6e9 = 5859375 * 2^10; the factor 4 of the counts per revolution
	// leaves a left shift of 8 on the numerator
	localparam int SCALE_W               = 23;
	localparam logic [SCALE_W-1:0] SPEED_SCALE = 23'd5859375;
	localparam int SPEED_SHIFT           = 8;
	localparam int SNUM_W                = COUNT_W + SCALE_W;
	localparam int SDEN_W                = PPR_W + TIME_W;

	// 36000 hundredths of a degree per revolution
	localparam logic [ANGLE_W-1:0] ANGLE_SCALE = 16'd36000;
	localparam int ANUM_W                = CPR_W + ANGLE_W;

	// shared divider
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 48;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	// item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_UPDATE = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLITCH_CYCLES  = 2'd1;

	// which quotient the divider is working on
	typedef enum logic [1:0] {
		DIV_SPEED = 2'd0,
		DIV_MOD   = 2'd1,
		DIV_ANGLE = 2'd2
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ABS,
		ST_MUL,
		ST_SPD_GO,
		ST_SPD_WAIT,
		ST_MOD_GO,
		ST_MOD_WAIT,
		ST_FIX,
		ST_AMUL,
		ST_ANG_GO,
		ST_ANG_WAIT,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic     sample;
		logic     clear;
		logic     update;
		logic     abs_en;
		logic     mul_en;
		logic     div_start;
		div_sel_t div_sel;
		logic     cap;
		logic     fix_en;
		logic     amul_en;
		logic     load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic out_full;
	} dp_status_t;

endpackage

// ===== hdl/qdsa_if.sv =====
// ----------------------------------------------------------------------------
// qdsa_if
// Valid/ready channels of the quadrature decoder: input items, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface qdsa_item_if;
	import qdsa_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic              pin_a;
	logic              pin_b;
	logic [TIME_W-1:0] time_us;

	modport source(output valid, kind, pin_a, pin_b, time_us, input ready);
	modport sink(input valid, kind, pin_a, pin_b, time_us, output ready);
endinterface

interface qdsa_result_if;
	import qdsa_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COUNT_W-1:0] shaft_count;
	logic signed [COUNT_W-1:0] speed_centi_rpm;
	logic [ANGLE_W-1:0]        angle_centi_deg;

	modport source(output valid, shaft_count, speed_centi_rpm, angle_centi_deg,
		input ready);
	modport sink(input valid, shaft_count, speed_centi_rpm, angle_centi_deg,
		output ready);
endinterface

interface qdsa_cfg_if;
	import qdsa_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/qdsa_div.sv =====
// ----------------------------------------------------------------------------
// qdsa_div
// Restoring unsigned divider, one quotient bit per cycle. A start pulse
// loads the operands; done pulses for a single cycle with the last step.
// ----------------------------------------------------------------------------
module qdsa_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [qdsa_pkg::DIV_NUM_W-1:0]  num,
	input  logic [qdsa_pkg::DIV_DEN_W-1:0]  den,
	output logic                            busy,
	output logic                            done,
	output logic [qdsa_pkg::DIV_NUM_W-1:0]  quot,
	output logic [qdsa_pkg::DIV_DEN_W-1:0]  rem
);
	import qdsa_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	// shift in the next numerator bit and try the subtraction
	always_comb begin
		trial = {rem_q, num_q[DIV_NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// step counter and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], ge};
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = num_q;
	assign rem  = rem_q;

endmodule

// ===== hdl/qdsa_dp.sv =====
// ----------------------------------------------------------------------------
// qdsa_dp
// Datapath: configuration registers, glitch filters, position counter,
// speed and angle arithmetic around the shared divider, result register.
// ----------------------------------------------------------------------------
module qdsa_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pin_a,
	input  logic                              pin_b,
	input  logic [qdsa_pkg::TIME_W-1:0]       time_us,
	input  logic                              cfg_valid,
	input  logic [qdsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qdsa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [qdsa_pkg::COUNT_W-1:0]      shaft_count,
	output logic [qdsa_pkg::COUNT_W-1:0]      speed_centi_rpm,
	output logic [qdsa_pkg::ANGLE_W-1:0]      angle_centi_deg,
	input  qdsa_pkg::dp_cmd_t                 cmd,
	output qdsa_pkg::dp_status_t              status
);
	import qdsa_pkg::*;

	typedef struct packed {
		logic                   stable;
		logic                   chg;
		logic [FILTER_BITS-1:0] cnt;
	} filt_t;

	// one glitch filter step for one pin
	function automatic filt_t filter_step(
		input logic                   raw,
		input logic                   stable,
		input logic [FILTER_BITS-1:0] cnt,
		input logic [FILTER_BITS-1:0] thr
	);
		filt_t                  r;
		logic [FILTER_BITS-1:0] nxt;
		r.stable = stable;
		r.chg    = 1'b0;
		r.cnt    = '0;
		nxt      = (cnt == FILTER_BITS'(CNT_MAX)) ? cnt : cnt + 1'b1;
		if (raw != stable) begin
			if (nxt >= thr) begin
				r.stable = raw;
				r.chg    = 1'b1;
			end else begin
				r.cnt = nxt;
			end
		end
		return r;
	endfunction

	logic [PPR_W-1:0]       ppr_q;
	logic [GLITCH_W-1:0]    glitch_q;
	logic [CPR_W-1:0]       cpr;
	logic [FILTER_BITS-1:0] thr;

	logic                   stable_a_q;
	logic                   stable_b_q;
	logic [FILTER_BITS-1:0] fcnt_a_q;
	logic [FILTER_BITS-1:0] fcnt_b_q;
	logic [COUNT_W-1:0]     pos_q;
	logic [COUNT_W-1:0]     prior_count_q;
	logic [TIME_W-1:0]      prior_time_q;
	filt_t                  fa;
	filt_t                  fb;
	logic                   step_en;
	logic                   step_up;

	logic [COUNT_W-1:0]     snap_q;
	logic [COUNT_W-1:0]     dc_q;
	logic [TIME_W-1:0]      dt_q;
	logic [COUNT_W-1:0]     mag_q;
	logic                   neg_q;
	logic [COUNT_W-1:0]     cabs_q;
	logic                   cneg_q;
	logic [SNUM_W-1:0]      snum_q;
	logic [SDEN_W-1:0]      sden_q;
	logic [CPR_W-1:0]       r_q;
	logic [CPR_W-1:0]       m_q;
	logic [ANUM_W-1:0]      anum_q;
	logic [COUNT_W-1:0]     speed_q;
	logic [ANGLE_W-1:0]     angle_q;
	logic [COUNT_W-1:0]     speed_sat;

	logic                   div_busy;
	logic                   div_done;
	logic [DIV_NUM_W-1:0]   div_num;
	logic [DIV_DEN_W-1:0]   div_den;
	logic [DIV_NUM_W-1:0]   div_quot;
	logic [DIV_DEN_W-1:0]   div_rem;

	logic                   out_valid_q;
	logic [COUNT_W-1:0]     out_count_q;
	logic [COUNT_W-1:0]     out_speed_q;
	logic [ANGLE_W-1:0]     out_angle_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q    <= '0;
			glitch_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PULSES_PER_REV: ppr_q    <= cfg_data[PPR_W-1:0];
				REG_GLITCH_CYCLES:  glitch_q <= cfg_data[GLITCH_W-1:0];
				default: ;
			endcase
		end
	end

	assign cpr = {ppr_q, 2'b00};

	// clip the threshold to the counter range
	always_comb begin
		thr = (32'(glitch_q) > CNT_MAX) ? FILTER_BITS'(CNT_MAX) : FILTER_BITS'(glitch_q);
	end

	// filter both pins and decode the 4x count step
	always_comb begin
		fa      = filter_step(pin_a, stable_a_q, fcnt_a_q, thr);
		fb      = filter_step(pin_b, stable_b_q, fcnt_b_q, thr);
		step_en = fa.chg ^ fb.chg;
		step_up = fa.chg ? (fa.stable == fb.stable) : (fa.stable != fb.stable);
	end

	// filter state, position count and reference point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_a_q    <= 1'b0;
			stable_b_q    <= 1'b0;
			fcnt_a_q      <= '0;
			fcnt_b_q      <= '0;
			pos_q         <= '0;
			prior_count_q <= '0;
			prior_time_q  <= '0;
		end else begin
			if (cmd.sample) begin
				stable_a_q <= fa.stable;
				stable_b_q <= fb.stable;
				fcnt_a_q   <= fa.cnt;
				fcnt_b_q   <= fb.cnt;
				if (step_en) begin
					pos_q <= step_up ? pos_q + 1'b1 : pos_q - 1'b1;
				end
			end
			if (cmd.clear) begin
				pos_q         <= '0;
				prior_count_q <= '0;
				prior_time_q  <= time_us;
			end
			if (cmd.update) begin
				prior_count_q <= pos_q;
				prior_time_q  <= time_us;
			end
		end
	end

	// snapshot, magnitudes and products for an update
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			snap_q <= pos_q;
			dc_q   <= pos_q - prior_count_q;
			dt_q   <= time_us - prior_time_q;
		end
		if (cmd.abs_en) begin
			mag_q  <= dc_q[COUNT_W-1] ? -dc_q : dc_q;
			neg_q  <= dc_q[COUNT_W-1];
			cabs_q <= snap_q[COUNT_W-1] ? -snap_q : snap_q;
			cneg_q <= snap_q[COUNT_W-1];
		end
		if (cmd.mul_en) begin
			snum_q <= SNUM_W'(mag_q) * SNUM_W'(SPEED_SCALE);
			sden_q <= SDEN_W'(ppr_q) * SDEN_W'(dt_q);
		end
		if (cmd.fix_en) begin
			m_q <= (cneg_q && (r_q != '0)) ? cpr - r_q : r_q;
		end
		if (cmd.amul_en) begin
			anum_q <= ANUM_W'(m_q) * ANUM_W'(ANGLE_SCALE);
		end
	end

	// pick divider operands
	always_comb begin
		unique case (cmd.div_sel)
			DIV_SPEED: begin
				div_num = DIV_NUM_W'({snum_q, {SPEED_SHIFT{1'b0}}});
				div_den = DIV_DEN_W'(sden_q);
			end
			DIV_MOD: begin
				div_num = DIV_NUM_W'(cabs_q);
				div_den = DIV_DEN_W'(cpr);
			end
			DIV_ANGLE: begin
				div_num = DIV_NUM_W'(anum_q);
				div_den = DIV_DEN_W'(cpr);
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	qdsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// sign and saturate the speed quotient; zero lines or zero time give 0
	always_comb begin
		if (sden_q == '0) begin
			speed_sat = '0;
		end else if (div_quot[DIV_NUM_W-1:COUNT_W-1] != '0) begin
			speed_sat = neg_q ? {1'b1, {(COUNT_W-1){1'b0}}} : {1'b0, {(COUNT_W-1){1'b1}}};
		end else begin
			speed_sat = neg_q ? -div_quot[COUNT_W-1:0] : div_quot[COUNT_W-1:0];
		end
	end

	// capture divider results
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			unique case (cmd.div_sel)
				DIV_SPEED: speed_q <= speed_sat;
				DIV_MOD:   r_q     <= div_rem[CPR_W-1:0];
				DIV_ANGLE: angle_q <= (ppr_q == '0) ? '0 : div_quot[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// result register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_count_q <= snap_q;
			out_speed_q <= speed_q;
			out_angle_q <= angle_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign shaft_count     = out_count_q;
	assign speed_centi_rpm = out_speed_q;
	assign angle_centi_deg = out_angle_q;

	assign status.div_busy = div_busy;
	assign status.div_done = div_done;
	assign status.out_full = out_valid_q && !out_ready;

endmodule

// ===== hdl/qdsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// qdsa_ctrl
// Controller: decodes accepted items and sequences the update arithmetic
// (magnitudes, products, three divisions, result load).
// ----------------------------------------------------------------------------
module qdsa_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic [qdsa_pkg::KIND_W-1:0]   item_kind,
	output logic                          item_ready,
	output qdsa_pkg::dp_cmd_t             cmd,
	input  qdsa_pkg::dp_status_t          status
);
	import qdsa_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = DIV_SPEED;
		item_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					unique case (item_kind)
						KIND_SAMPLE: cmd.sample = 1'b1;
						KIND_CLEAR:  cmd.clear  = 1'b1;
						KIND_UPDATE: begin
							cmd.update = 1'b1;
							state_d    = ST_ABS;
						end
						default: ;
					endcase
				end
			end
			ST_ABS: begin
				cmd.abs_en = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_SPD_GO;
			end
			ST_SPD_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_SPD_WAIT;
			end
			ST_SPD_WAIT: begin
				if (status.div_done) begin
					cmd.cap = 1'b1;
					state_d = ST_MOD_GO;
				end
			end
			ST_MOD_GO: begin
				cmd.div_sel   = DIV_MOD;
				cmd.div_start = 1'b1;
				state_d       = ST_MOD_WAIT;
			end
			ST_MOD_WAIT: begin
				cmd.div_sel = DIV_MOD;
				if (status.div_done) begin
					cmd.cap = 1'b1;
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.fix_en = 1'b1;
				state_d    = ST_AMUL;
			end
			ST_AMUL: begin
				cmd.amul_en = 1'b1;
				state_d     = ST_ANG_GO;
			end
			ST_ANG_GO: begin
				cmd.div_sel   = DIV_ANGLE;
				cmd.div_start = 1'b1;
				state_d       = ST_ANG_WAIT;
			end
			ST_ANG_WAIT: begin
				cmd.div_sel = DIV_ANGLE;
				if (status.div_done) begin
					cmd.cap = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for the result register to drain
				if (!status.out_full) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hdl/quadrature_decoder_speed_angle_unit.sv =====
// ----------------------------------------------------------------------------
// quadrature_decoder_speed_angle_unit
// 4x quadrature decoder with glitch filters, speed and angle readout.
// ----------------------------------------------------------------------------
// Usage:
//  item   : valid/ready input. kind 0 carries one sample of pins A and B,
//           kind 1 requests an update, kind 2 clears the count at time_us.
//  result : valid/ready output, one transfer per update item: count,
//           speed in 0.01 rpm since the previous update or clear, angle in
//           0.01 degree.
//  cfg    : register writes, always ready; index 0 lines per revolution,
//           index 1 glitch filter length. Write only while the block is idle.
// Throughput: samples, clears and unused kinds may follow back to back. An
//  update runs the shared 64-step divider three times, and no item is taken
//  from its acceptance until the result is loaded into its register.
// Reset clears the count, filters, reference point and both registers.
// A stalled result holds in its register while the next items are taken;
//  only a second update waits for that transfer before its load.
// ----------------------------------------------------------------------------
module quadrature_decoder_speed_angle_unit (
	input  logic          clk,
	input  logic          arst_n,
	qdsa_item_if.sink     item,
	qdsa_result_if.source result,
	qdsa_cfg_if.sink      cfg
);
	import qdsa_pkg::*;

	dp_cmd_t               cmd;
	dp_status_t            status;
	logic [COUNT_W-1:0]    shaft_count;
	logic [COUNT_W-1:0]    speed_centi_rpm;

	assign cfg.ready = 1'b1;

	// sequencer
	qdsa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_kind  (item.kind),
		.item_ready (item.ready),
		.cmd        (cmd),
		.status     (status)
	);

	// arithmetic and state
	qdsa_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.pin_a           (item.pin_a),
		.pin_b           (item.pin_b),
		.time_us         (item.time_us),
		.cfg_valid       (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.out_ready       (result.ready),
		.out_valid       (result.valid),
		.shaft_count     (shaft_count),
		.speed_centi_rpm (speed_centi_rpm),
		.angle_centi_deg (result.angle_centi_deg),
		.cmd             (cmd),
		.status          (status)
	);

	assign result.shaft_count     = signed'(shaft_count);
	assign result.speed_centi_rpm = signed'(speed_centi_rpm);

`ifndef SYNTH
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_busy |-> !item.ready)
		else $error("item ready while divider busy");

	a_update_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.kind == KIND_UPDATE) |=> !item.ready)
		else $error("item taken right after an update");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.angle_centi_deg < ANGLE_SCALE))
		else $error("angle out of range");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.load_out))
		else $error("result valid without load");
`endif

endmodule

// ===== tb/quadrature_decoder_speed_angle_unit_tb.sv =====
// ----------------------------------------------------------------------------
// quadrature_decoder_speed_angle_unit_tb
// Self-checking bench for the quadrature decoder. It walks the encoder pins
// through clean and noisy quadrature sequences under several line counts and
// glitch filter lengths. It also sends update, clear and unused items, tracks
// filters, count, speed and angle in a local decoder model, and compares every
// readout field with the oldest predicted one.
// ----------------------------------------------------------------------------
module quadrature_decoder_speed_angle_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qdsa_pkg::*;

	localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

	localparam int CLK_PERIOD    = 12;
	localparam int SETTLE_CYCLES = 220;
	localparam int STALL_LIMIT   = 5000;
	localparam longint unsigned CENTI_RPM_NUM = 64'd6000000000;

	typedef struct {
		logic signed [COUNT_W-1:0] count;
		logic signed [COUNT_W-1:0] speed;
		logic [ANGLE_W-1:0]        angle;
	} readout_t;

	logic clk;
	logic arst_n;

	qdsa_item_if   item_bus();
	qdsa_result_if result_bus();
	qdsa_cfg_if    cfg_bus();

	quadrature_decoder_speed_angle_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// decoder model state
	logic [PPR_W-1:0]       lines_per_rev;
	logic [GLITCH_W-1:0]    glitch_len;
	logic [FILTER_BITS-1:0] filt_cnt_a;
	logic [FILTER_BITS-1:0] filt_cnt_b;
	logic                   lvl_a;
	logic                   lvl_b;
	logic [COUNT_W-1:0]     position;
	logic [COUNT_W-1:0]     mark_position;
	logic [TIME_W-1:0]      mark_time;

	readout_t pending_readouts[$];

	logic [TIME_W-1:0] clock_us;
	bit send_burst;
	bit recv_burst;
	int mismatches;
	int n_samples, n_updates, n_clears, n_unused, n_checked, n_settings;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// decoder model
	// ------------------------------------------------------------------------

	// glitch filter of one pin; returns 1 when a new level is taken
	function automatic logic filter_accepts(input logic raw, inout logic lvl,
		inout logic [FILTER_BITS-1:0] cnt);
		int thr;
		int nxt;
		thr = (glitch_len > CNT_MAX) ? CNT_MAX : int'(glitch_len);
		if (raw == lvl) begin
			cnt = '0;
			return 1'b0;
		end
		nxt = (cnt < CNT_MAX) ? int'(cnt) + 1 : CNT_MAX;
		if (nxt >= thr) begin
			lvl = raw;
			cnt = '0;
			return 1'b1;
		end
		cnt = nxt[FILTER_BITS-1:0];
		return 1'b0;
	endfunction

	function automatic void count_sample(input logic a, input logic b);
		logic ch_a;
		logic ch_b;
		logic up;
		ch_a = filter_accepts(a, lvl_a, filt_cnt_a);
		ch_b = filter_accepts(b, lvl_b, filt_cnt_b);
		// both filtered pins moved at once: direction unknown, hold count
		if (ch_a && ch_b)
			return;
		if (ch_a) begin
			up = lvl_a;
			if (!lvl_b)
				up = !up;
			position = up ? position + 1'b1 : position - 1'b1;
		end else if (ch_b) begin
			up = !lvl_b;
			if (!lvl_a)
				up = !up;
			position = up ? position + 1'b1 : position - 1'b1;
		end
	endfunction

	function automatic logic signed [COUNT_W-1:0] predicted_speed(
		input logic [TIME_W-1:0] dt);
		longint unsigned cpr;
		longint unsigned mag;
		longint unsigned quo;
		logic [COUNT_W-1:0] dc;
		logic [COUNT_W-1:0] dmag;
		cpr = 64'(lines_per_rev);
		cpr = cpr * 4;
		dc = position - mark_position;
		dmag = dc[COUNT_W-1] ? -dc : dc;
		mag = 64'(dmag);
		if (cpr == 0 || dt == 0)
			return '0;
		quo = (mag * CENTI_RPM_NUM) / (cpr * 64'(dt));
		// saturate to the signed 32-bit range
		if (dc[COUNT_W-1]) begin
			if (quo >= 64'h8000_0000)
				return 32'h8000_0000;
			return -quo[COUNT_W-1:0];
		end
		if (quo > 64'h7FFF_FFFF)
			return 32'h7FFF_FFFF;
		return quo[COUNT_W-1:0];
	endfunction

	function automatic logic [ANGLE_W-1:0] predicted_angle();
		longint cpr;
		longint c;
		longint m;
		cpr = longint'(lines_per_rev);
		cpr = cpr * 4;
		if (cpr == 0)
			return '0;
		c = longint'($signed(position));
		m = c % cpr;
		if (m < 0)
			m = m + cpr;
		m = (m * 36000) / cpr;
		return m[ANGLE_W-1:0];
	endfunction

	function automatic void predict_item(input logic [KIND_W-1:0] kind,
		input logic a, input logic b, input logic [TIME_W-1:0] t);
		readout_t r;
		case (kind)
			KIND_SAMPLE: begin
				count_sample(a, b);
			end
			KIND_CLEAR: begin
				position = '0;
				mark_position = '0;
				mark_time = t;
			end
			KIND_UPDATE: begin
				r.count = position;
				r.speed = predicted_speed(t - mark_time);
				r.angle = predicted_angle();
				pending_readouts.push_back(r);
				mark_position = position;
				mark_time = t;
			end
			default: begin
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// channel drivers
	// ------------------------------------------------------------------------

	// one item transfer, with a random gap ahead of it
	task automatic send_item(input logic [KIND_W-1:0] kind, input logic a,
		input logic b, input logic [TIME_W-1:0] t);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid   <= 1'b1;
		item_bus.kind    <= kind;
		item_bus.pin_a   <= a;
		item_bus.pin_b   <= b;
		item_bus.time_us <= t;
		do @(posedge clk); while (!(item_bus.valid && item_bus.ready));
		predict_item(kind, a, b, t);
		case (kind)
			KIND_SAMPLE: n_samples++;
			KIND_UPDATE: n_updates++;
			KIND_CLEAR:  n_clears++;
			default:     n_unused++;
		endcase
	endtask

	task automatic send_sample(input logic [1:0] lv);
		send_item(KIND_SAMPLE, lv[1], lv[0], $urandom);
	endtask

	// register write; valid stays high for a following write
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] reg_idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= reg_idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
		case (reg_idx)
			REG_PULSES_PER_REV: lines_per_rev = data;
			REG_GLITCH_CYCLES:  glitch_len = data[GLITCH_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic write_regs(input logic [PPR_W-1:0] ppr,
		input logic [CFG_DATA_W-1:0] glitch_word);
		cfg_write(REG_PULSES_PER_REV, ppr);
		cfg_write(REG_GLITCH_CYCLES, glitch_word);
		cfg_bus.valid <= 1'b0;
		n_settings++;
	endtask

	// hold items until every readout is back and the block has settled
	task automatic wait_idle();
		item_bus.valid <= 1'b0;
		while (pending_readouts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// pin levels {a, b} of one quadrature phase
	function automatic logic [1:0] quad_levels(input int ph);
		case (ph & 3)
			0:       return 2'b00;
			1:       return 2'b10;
			2:       return 2'b11;
			default: return 2'b01;
		endcase
	endfunction

	function automatic int phase_of_levels();
		for (int p = 0; p < 4; p++)
			if (quad_levels(p) == {lvl_a, lvl_b})
				return p;
		return 0;
	endfunction

	function automatic logic [TIME_W-1:0] time_step();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return $urandom;
			2, 3:    return $urandom_range(1, 20);
			default: return $urandom_range(20, 200000);
		endcase
	endfunction

	task automatic send_update();
		clock_us = clock_us + time_step();
		send_item(KIND_UPDATE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			clock_us);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// registers at reset: no lines, instant filter
	task automatic test_reset_registers();
		send_sample(2'b01);
		send_sample(2'b11);
		send_sample(2'b10);
		send_sample(2'b00);
		send_item(KIND_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_item(KIND_UPDATE, 1'b0, 1'b0, 32'd1000);
	endtask

	// one line per rev: saturation both ways, wrapped and zero intervals,
	// both pins at once, time extremes
	task automatic test_corner_items();
		wait_idle();
		write_regs(16'd1, 16'd0);
		send_item(KIND_CLEAR, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_sample(2'b10);
		send_sample(2'b11);
		send_item(KIND_UPDATE, 1'b0, 1'b0, 32'd0);
		send_item(KIND_UPDATE, 1'b1, 1'b0, 32'd0);
		send_sample(2'b00);
		send_sample(2'b11);
		send_sample(2'b10);
		send_sample(2'b00);
		send_sample(2'b01);
		send_item(KIND_UPDATE, 1'b0, 1'b1, 32'd1);
		send_item(KIND_UNUSED, 1'b0, 1'b1, 32'hA5A5_5A5A);
		send_item(KIND_UPDATE, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_item(KIND_CLEAR, 1'b0, 1'b0, 32'd0);
		send_item(KIND_UPDATE, 1'b0, 1'b0, 32'h8000_0000);
	endtask

	// widest line count; glitch word with upper bits that must be dropped
	task automatic test_max_lines();
		int ph;
		wait_idle();
		cfg_write(REG_UNUSED, 16'hFFFF);
		write_regs(16'hFFFF, 16'hFC01);
		ph = phase_of_levels();
		send_item(KIND_CLEAR, 1'b0, 1'b1, 32'd100);
		repeat (3) begin
			ph++;
			send_sample(quad_levels(ph));
		end
		send_item(KIND_UPDATE, 1'b1, 1'b0, 32'd101);
		repeat (5) begin
			ph--;
			send_sample(quad_levels(ph));
		end
		send_item(KIND_UPDATE, 1'b0, 1'b1, 32'd40000101);
	endtask

	// longest filter: a level held one sample short is ignored, then taken
	task automatic test_longest_filter();
		logic target;
		wait_idle();
		write_regs(PPR_W'($urandom_range(1, 2000)), {6'($urandom), 10'h3FF});
		target = !lvl_a;
		clock_us = $urandom;
		send_item(KIND_CLEAR, 1'b0, 1'b0, clock_us);
		repeat (CNT_MAX - 1)
			send_item(KIND_SAMPLE, target, lvl_b, $urandom);
		send_update();
		send_item(KIND_SAMPLE, target, lvl_b, $urandom);
		send_update();
		// short pulse back: filter restarts and drops it
		repeat (5)
			send_item(KIND_SAMPLE, !target, lvl_b, $urandom);
		send_item(KIND_SAMPLE, target, lvl_b, $urandom);
		send_update();
	endtask

	// random shaft motion with noise, updates and clears
	task automatic test_random_motion(input logic [PPR_W-1:0] ppr,
		input logic [CFG_DATA_W-1:0] glitch_word, input int n_items);
		int sent;
		int ph;
		int dir;
		int need;
		int hold;
		int pick;
		sent = 0;
		wait_idle();
		write_regs(ppr, glitch_word);
		need = (glitch_len < 1) ? 1 : int'(glitch_len);
		ph = phase_of_levels();
		dir = $urandom_range(0, 1) ? 1 : -1;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				// advance one phase, now and then skip one
				if ($urandom_range(0, 9) == 0)
					dir = -dir;
				ph = ph + dir;
				if ($urandom_range(0, 19) == 0)
					ph = ph + dir;
				hold = need + $urandom_range(0, 2);
				repeat (hold)
					send_sample(quad_levels(ph));
				sent += hold;
			end else if (pick < 75) begin
				// short random burst, mostly below the filter length
				hold = $urandom_range(1, (need > 1) ? need - 1 : 1);
				repeat (hold)
					send_sample(2'($urandom));
				sent += hold;
			end else if (pick < 88) begin
				send_update();
				sent++;
			end else if (pick < 91) begin
				clock_us = clock_us + time_step();
				send_item(KIND_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					clock_us);
				sent++;
			end else if (pick < 93) begin
				send_item(KIND_UNUSED, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					$urandom);
			end else begin
				send_sample(2'($urandom));
				sent++;
			end
		end
		send_update();
	endtask

	// ------------------------------------------------------------------------
	// result side: random stalls, then compare each readout
	// ------------------------------------------------------------------------
	initial begin
		int stall;
		result_bus.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 7) == 0)
				recv_burst = !recv_burst;
			stall = recv_burst ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				result_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			do @(posedge clk); while (!(result_bus.valid && result_bus.ready));
		end
	end

	always @(posedge clk) begin
		readout_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_readouts.size() == 0) begin
				$error("readout with none pending: count %0d speed %0d angle %0d",
					result_bus.shaft_count, result_bus.speed_centi_rpm,
					result_bus.angle_centi_deg);
				mismatches++;
			end else begin
				want = pending_readouts.pop_front();
				n_checked++;
				if (result_bus.shaft_count !== want.count) begin
					$error("shaft_count: expected %0d, got %0d", want.count,
						result_bus.shaft_count);
					mismatches++;
				end
				if (result_bus.speed_centi_rpm !== want.speed) begin
					$error("speed_centi_rpm: expected %0d, got %0d", want.speed,
						result_bus.speed_centi_rpm);
					mismatches++;
				end
				if (result_bus.angle_centi_deg !== want.angle) begin
					$error("angle_centi_deg: expected %0d, got %0d", want.angle,
						result_bus.angle_centi_deg);
					mismatches++;
				end
			end
		end
	end

	// stop a hung run: count cycles with no transfer on any channel
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_bus.valid && item_bus.ready) ||
				(result_bus.valid && result_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n           <= 1'b0;
		item_bus.valid   <= 1'b0;
		item_bus.kind    <= KIND_SAMPLE;
		item_bus.pin_a   <= 1'b0;
		item_bus.pin_b   <= 1'b0;
		item_bus.time_us <= '0;
		cfg_bus.valid    <= 1'b0;
		cfg_bus.index    <= REG_PULSES_PER_REV;
		cfg_bus.data     <= '0;
		lines_per_rev = '0;
		glitch_len    = '0;
		filt_cnt_a    = '0;
		filt_cnt_b    = '0;
		lvl_a         = 1'b0;
		lvl_b         = 1'b0;
		position      = '0;
		mark_position = '0;
		mark_time     = '0;
		clock_us      = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_registers();
		test_corner_items();
		test_max_lines();
		test_longest_filter();
		test_random_motion(16'd1, 16'd0, 50);
		test_random_motion(PPR_W'($urandom_range(2, 500)), 16'd1, 50);
		test_random_motion(16'hFFFF, 16'd3, 40);
		test_random_motion(PPR_W'($urandom_range(1, 65535)),
			CFG_DATA_W'($urandom_range(2, 6)), 50);
		test_random_motion(16'd0, 16'd2, 35);
		test_random_motion(PPR_W'($urandom_range(1, 30)), {6'($urandom), 10'd0}, 50);
		wait_idle();

		$display("sent %0d samples, %0d updates, %0d clears, %0d unused-kind items",
			n_samples, n_updates, n_clears, n_unused);
		$display("compared %0d readouts over %0d register settings",
			n_checked, n_settings);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
